### rtl/drm_pkg.sv
// Shared types, constants and helpers of the drum rotation monitor.
package drm_pkg;

  localparam int SPEED_W    = 14;
  localparam int PERIOD_W   = 32;
  localparam int MAGNETS_W  = 8;
  localparam int TIMEOUT_W  = 16;
  localparam int PROD_W     = PERIOD_W + MAGNETS_W;
  localparam int SILENCE_W  = 17;
  localparam int CHANGE_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEPS  = SPEED_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [SPEED_W-1:0]   SPEED_SCALE    = SPEED_W'(12000);
  localparam logic [CHANGE_W-1:0]  CHANGE_CONFIRM = CHANGE_W'(4);
  localparam logic [SILENCE_W-1:0] SILENCE_MAX    = '1;
  localparam logic [MAGNETS_W-1:0] MAGNETS_RESET  = MAGNETS_W'(4);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = TIMEOUT_W'(640);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAGNETS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    ROT_STOPPED = 2'd0,
    ROT_FORWARD = 2'd1,
    ROT_REVERSE = 2'd2,
    ROT_UNKNOWN = 2'd3
  } rot_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic prep;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_pulse;
    logic pulse_started;
    logic div_needed;
  } sts_t;

  function automatic rot_state_t dir_state(input logic dir);
    return dir ? ROT_FORWARD : ROT_REVERSE;
  endfunction

endpackage

### rtl/drm_ctrl.sv
// Sequencing controller of the drum rotation monitor.
module drm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  drm_pkg::sts_t sts,
  output drm_pkg::cmd_t cmd
);
  import drm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PREP,
    S_DIV,
    S_COMMIT
  } ctrl_state_t;

  ctrl_state_t          state;
  logic [DIV_CNT_W-1:0] step_cnt;
  logic                 slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.mul    = (state == S_MUL);
    cmd.prep   = (state == S_PREP);
    cmd.step   = (state == S_DIV);
    cmd.commit = (state == S_COMMIT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !cmd.commit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (sts.is_pulse && sts.pulse_started) begin
            state <= S_PREP;
          end else begin
            state <= S_COMMIT;
          end
        end
        S_PREP: begin
          step_cnt <= '0;
          if (sts.div_needed) begin
            state <= S_DIV;
          end else begin
            state <= S_COMMIT;
          end
        end
        S_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> step_cnt < DIV_CNT_W'(DIV_STEPS))
    else $error("divider ran past its last step");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("commit overwrote a waiting result");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall && !cmd.commit)
    else $error("request not held for processing");

endmodule

### rtl/drm_dp.sv
// Datapath of the drum rotation monitor: registers, speed divider, state update.
module drm_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [drm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [drm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              kind,
  input  logic                              ignition_on,
  input  logic                              direction_level,
  input  logic [drm_pkg::PERIOD_W-1:0]      timestamp,
  input  drm_pkg::cmd_t                     cmd,
  output drm_pkg::sts_t                     sts,
  output logic [1:0]                        rotation_state,
  output logic [1:0]                        line_code,
  output logic [drm_pkg::SPEED_W-1:0]       speed,
  output logic                              report_event
);
  import drm_pkg::*;

  logic [MAGNETS_W-1:0] magnets;
  logic [TIMEOUT_W-1:0] timeout;

  logic                item_kind;
  logic                item_ign;
  logic                item_dir;
  logic [PERIOD_W-1:0] item_ts;

  logic [PROD_W-1:0]  prod;
  logic [SPEED_W-1:0] quo;
  logic [SPEED_W-1:0] rem;
  logic [SPEED_W-1:0] dvs;
  logic [SPEED_W:0]   rem_sh;
  logic [SPEED_W+1:0] diff;

  rot_state_t           rot;
  rot_state_t           rot_next;
  rot_state_t           reported;
  rot_state_t           reported_next;
  logic                 first_tick_done;
  logic                 first_tick_done_next;
  logic                 pulse_started;
  logic                 pulse_started_next;
  logic [PERIOD_W-1:0]  last_pulse_time;
  logic [PERIOD_W-1:0]  last_pulse_time_next;
  logic [SPEED_W-1:0]   speed_reg;
  logic [SPEED_W-1:0]   speed_reg_next;
  logic [CHANGE_W-1:0]  change_cnt;
  logic [CHANGE_W-1:0]  change_cnt_next;
  logic                 last_dir;
  logic                 last_dir_next;
  logic [SILENCE_W-1:0] silence;
  logic [SILENCE_W-1:0] silence_next;
  logic                 event_next;
  rot_state_t           rot_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      magnets <= MAGNETS_RESET;
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAGNETS: magnets <= cfg_data[MAGNETS_W-1:0];
        CFG_TIMEOUT: timeout <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture, period product and the restoring divider for 12000 / product.
  assign rem_sh = {rem, quo[SPEED_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind <= kind;
      item_ign  <= ignition_on;
      item_dir  <= direction_level;
      item_ts   <= timestamp;
    end
    if (cmd.mul) begin
      prod <= {{MAGNETS_W{1'b0}}, item_ts - last_pulse_time}
            * {{PERIOD_W{1'b0}}, magnets};
    end
    if (cmd.prep) begin
      rem <= '0;
      dvs <= prod[SPEED_W-1:0];
      if (prod == '0) begin
        quo <= SPEED_SCALE;
      end else if (prod > PROD_W'(SPEED_SCALE)) begin
        quo <= '0;
      end else begin
        quo <= SPEED_SCALE;
      end
    end else if (cmd.step) begin
      if (!diff[SPEED_W+1]) begin
        rem <= diff[SPEED_W-1:0];
        quo <= {quo[SPEED_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[SPEED_W-1:0];
        quo <= {quo[SPEED_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sts               = '0;
    sts.is_pulse      = item_kind;
    sts.pulse_started = pulse_started;
    sts.div_needed    = (prod != '0) && (prod <= PROD_W'(SPEED_SCALE));
  end

  always_comb begin
    rot_next             = rot;
    reported_next        = reported;
    first_tick_done_next = first_tick_done;
    pulse_started_next   = pulse_started;
    last_pulse_time_next = last_pulse_time;
    speed_reg_next       = speed_reg;
    change_cnt_next      = change_cnt;
    last_dir_next        = last_dir;
    silence_next         = silence;
    event_next           = 1'b0;
    rot_tick             = first_tick_done ? rot : dir_state(item_dir);

    if (item_kind) begin
      if (change_cnt == '0) begin
        change_cnt_next = CHANGE_W'(1);
      end
      last_pulse_time_next = item_ts;
      if (pulse_started) begin
        speed_reg_next = quo;
      end else begin
        pulse_started_next = 1'b1;
      end
    end else if (!item_ign) begin
      rot_next             = ROT_UNKNOWN;
      speed_reg_next       = '0;
      change_cnt_next      = '0;
      pulse_started_next   = 1'b0;
      last_dir_next        = 1'b0;
      last_pulse_time_next = item_ts;
    end else begin
      first_tick_done_next = 1'b1;
      rot_next             = rot_tick;
      if (change_cnt == '0) begin
        if (rot_tick == ROT_FORWARD || rot_tick == ROT_REVERSE) begin
          if (silence != SILENCE_MAX) begin
            silence_next = silence + 1'b1;
          end
          if (silence > {1'b0, timeout}) begin
            rot_next       = ROT_STOPPED;
            speed_reg_next = '0;
          end
        end
      end else if (change_cnt < CHANGE_CONFIRM) begin
        silence_next = '0;
        if (rot_tick == ROT_STOPPED) begin
          change_cnt_next = '0;
          last_dir_next   = item_dir;
          rot_next        = dir_state(item_dir);
        end else if (item_dir != last_dir) begin
          change_cnt_next = change_cnt + 1'b1;
        end else begin
          change_cnt_next = '0;
        end
      end else begin
        // A direction change has been seen on enough ticks: take it.
        change_cnt_next    = '0;
        pulse_started_next = 1'b0;
        speed_reg_next     = '0;
        last_dir_next      = item_dir;
        silence_next       = '0;
        rot_next           = dir_state(item_dir);
      end
      event_next    = (reported != rot_next);
      reported_next = rot_next;
    end

    if (rot_next == ROT_STOPPED || change_cnt_next > CHANGE_W'(1)) begin
      speed_reg_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot             <= ROT_UNKNOWN;
      reported        <= ROT_UNKNOWN;
      first_tick_done <= 1'b0;
      pulse_started   <= 1'b0;
      last_pulse_time <= '0;
      speed_reg       <= '0;
      change_cnt      <= '0;
      last_dir        <= 1'b0;
      silence         <= '0;
    end else if (cmd.commit) begin
      rot             <= rot_next;
      reported        <= reported_next;
      first_tick_done <= first_tick_done_next;
      pulse_started   <= pulse_started_next;
      last_pulse_time <= last_pulse_time_next;
      speed_reg       <= speed_reg_next;
      change_cnt      <= change_cnt_next;
      last_dir        <= last_dir_next;
      silence         <= silence_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rotation_state <= rot_next;
      line_code      <= ROT_UNKNOWN - rot_next;
      speed          <= speed_reg_next;
      report_event   <= event_next;
    end
  end

endmodule

### rtl/drum_rotation_speed_direction_monitor.sv
// Top level of the drum rotation speed and direction monitor.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    kind, ignition_on, direction_level, timestamp
//   out      out_valid / out_stall  rotation_state, line_code, speed, report_event
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A tick, or a pulse with no earlier pulse, passes from acceptance through the multiply
// and commit states to its result. A measured pulse adds the prep state when the quotient
// is known without dividing, and the prep state and the 14-step restoring divider when the
// speed needs it.
// One request is in flight at a time; in_stall is high from acceptance until the
// result has been loaded into the output register.
// A result waiting under out_stall holds the next request at its final step.
// Reset (synchronous) loads the register defaults and the unknown rotation state.
module drum_rotation_speed_direction_monitor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic                              ignition_on,
  input  logic                              direction_level,
  input  logic [drm_pkg::PERIOD_W-1:0]      timestamp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        rotation_state,
  output logic [1:0]                        line_code,
  output logic [drm_pkg::SPEED_W-1:0]       speed,
  output logic                              report_event,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [drm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [drm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import drm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Register writes are always accepted.
  assign cfg_ready = 1'b1;

  drm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  drm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .ignition_on     (ignition_on),
    .direction_level (direction_level),
    .timestamp       (timestamp),
    .cmd             (cmd),
    .sts             (sts),
    .rotation_state  (rotation_state),
    .line_code       (line_code),
    .speed           (speed),
    .report_event    (report_event)
  );

endmodule
